[rtl/core/ordered_list_pair_sum_engine_macros.svh]
// assertion macros shared by the ordered list engine modules
// expects clk and rst in the scope of each use
`ifndef ORDERED_LIST_PAIR_SUM_ENGINE_MACROS_SVH
`define ORDERED_LIST_PAIR_SUM_ENGINE_MACROS_SVH

// same-cycle implication
`define OLPSE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("olpse: check failed");

// next-cycle implication
`define OLPSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("olpse: check failed");

`endif

[rtl/core/olpse_pkg.sv]
// shared types and constants of the ordered list pair-sum engine
// no dependencies
package olpse_pkg;

  localparam int DEPTH    = 8;
  localparam int MAX_OUT  = 28;
  localparam int ACTION_W = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = $clog2(DEPTH);
  // pointers run up to depth plus one during the pair walk
  localparam int CNT_W    = $clog2(DEPTH + 2);
  localparam int PAIR_W   = $clog2(MAX_OUT + 1);
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_HEAD = 4'd0,
    ACT_INS_TAIL = 4'd1,
    ACT_INS_POS  = 4'd2,
    ACT_DEL_HEAD = 4'd3,
    ACT_DEL_TAIL = 4'd4,
    ACT_DEL_POS  = 4'd5,
    ACT_READ_ALL = 4'd6,
    ACT_PAIR     = 4'd7,
    ACT_CLEAR    = 4'd8
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_BADPOS = 3'd2,
    ST_FULL   = 3'd3,
    ST_NOPAIR = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2,
    CNT_CLR  = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    logic    start;
    logic    shift_rd;
    logic    wr_shift;
    logic    wr_new;
    logic    cap_read;
    logic    cap_pair;
    logic    inc_i;
    logic    adv_pair;
    cnt_op_t cnt_op;
    logic    emit;
    status_t emit_status;
    logic    emit_last;
    logic    emit_hold;
  } dp_cmd_t;

  typedef struct packed {
    action_t act;
    logic    empty;
    logic    full;
    logic    bad_ins_pos;
    logic    bad_del_pos;
    logic    is_del;
    logic    shift_more;
    logic    rd_last;
    logic    pair_in_range;
    logic    match;
    logic    pair_limit;
    logic    pend_valid;
  } dp_status_t;

endpackage

[rtl/core/olpse_if.sv]
// request and response channel interfaces of the ordered list engine
// depends on olpse_pkg
interface olpse_req_if import olpse_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [VALUE_W-1:0]  item_value;
  logic [POS_W-1:0]           list_position;
  logic signed [VALUE_W-1:0]  target_sum;

  modport source (output valid, action, item_value, list_position, target_sum,
                  input ready);
  modport sink (input valid, action, item_value, list_position, target_sum,
                output ready);
endinterface

interface olpse_rsp_if import olpse_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  first_value;
  logic signed [VALUE_W-1:0]  second_value;
  logic                       last;

  modport source (output valid, status, first_value, second_value, last,
                  input ready);
  modport sink (input valid, status, first_value, second_value, last,
                output ready);
endinterface

[rtl/core/olpse_ctrl.sv]
// controller state machine of the ordered list engine
// depends on olpse_pkg and the assertion macro header
`include "ordered_list_pair_sum_engine_macros.svh"

module olpse_ctrl import olpse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_fire,
  input  logic       out_free,
  input  dp_status_t stat,
  output logic       idle,
  output dp_cmd_t    cmd
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_DECODE  = 15'h0002,
    S_SH_TEST = 15'h0004,
    S_SH_RD   = 15'h0008,
    S_SH_WR   = 15'h0010,
    S_INS_PUT = 15'h0020,
    S_DEL_RD  = 15'h0040,
    S_DEL_CAP = 15'h0080,
    S_RD_ADDR = 15'h0100,
    S_RD_CAP  = 15'h0200,
    S_RD_EMIT = 15'h0400,
    S_PS_ADDR = 15'h0800,
    S_PS_CMP  = 15'h1000,
    S_PS_END  = 15'h2000,
    S_REPLY   = 15'h4000
  } state_t;

  state_t  state, state_next;
  status_t r_status, r_status_next;
  logic    r_hold, r_hold_next;
  cnt_op_t r_cnt, r_cnt_next;

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      r_status <= ST_OK;
      r_hold   <= 1'b0;
      r_cnt    <= CNT_KEEP;
    end else begin
      state    <= state_next;
      r_status <= r_status_next;
      r_hold   <= r_hold_next;
      r_cnt    <= r_cnt_next;
    end
  end

  always_comb begin
    state_next    = state;
    r_status_next = r_status;
    r_hold_next   = r_hold;
    r_cnt_next    = r_cnt;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        // default is a plain one-transaction reply with zero values
        r_hold_next = 1'b0;
        r_cnt_next  = CNT_KEEP;
        state_next  = S_REPLY;
        unique case (stat.act) inside
          ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
            if ((stat.act == ACT_INS_POS) && stat.bad_ins_pos) begin
              r_status_next = ST_BADPOS;
            end else if (stat.full) begin
              r_status_next = ST_FULL;
            end else begin
              cmd.start     = 1'b1;
              r_status_next = ST_OK;
              r_cnt_next    = CNT_INC;
              state_next    = S_SH_TEST;
            end
          end
          ACT_DEL_HEAD, ACT_DEL_TAIL, ACT_DEL_POS: begin
            if (stat.empty) begin
              r_status_next = ST_EMPTY;
            end else if ((stat.act == ACT_DEL_POS) && stat.bad_del_pos) begin
              r_status_next = ST_BADPOS;
            end else begin
              cmd.start     = 1'b1;
              r_status_next = ST_OK;
              r_hold_next   = 1'b1;
              r_cnt_next    = CNT_DEC;
              state_next    = S_DEL_RD;
            end
          end
          ACT_READ_ALL, ACT_PAIR: begin
            if (stat.empty) begin
              r_status_next = ST_EMPTY;
            end else begin
              cmd.start  = 1'b1;
              state_next = (stat.act == ACT_PAIR) ? S_PS_ADDR : S_RD_ADDR;
            end
          end
          ACT_CLEAR: begin
            r_status_next = ST_OK;
            r_cnt_next    = CNT_CLR;
          end
          default: begin
            // unused codes give no transaction
            state_next = S_IDLE;
          end
        endcase
      end
      S_SH_TEST: begin
        if (stat.shift_more) begin
          state_next = S_SH_RD;
        end else if (stat.is_del) begin
          state_next = S_REPLY;
        end else begin
          state_next = S_INS_PUT;
        end
      end
      S_SH_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SH_TEST;
      end
      S_INS_PUT: begin
        cmd.wr_new = 1'b1;
        state_next = S_REPLY;
      end
      S_DEL_RD: begin
        state_next = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd.cap_read = 1'b1;
        state_next   = S_SH_TEST;
      end
      S_RD_ADDR: begin
        state_next = S_RD_CAP;
      end
      S_RD_CAP: begin
        cmd.cap_read = 1'b1;
        state_next   = S_RD_EMIT;
      end
      S_RD_EMIT: begin
        if (out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_hold   = 1'b1;
          cmd.emit_last   = stat.rd_last;
          cmd.inc_i       = 1'b1;
          state_next      = stat.rd_last ? S_IDLE : S_RD_ADDR;
        end
      end
      S_PS_ADDR: begin
        state_next = stat.pair_in_range ? S_PS_CMP : S_PS_END;
      end
      S_PS_CMP: begin
        if (!stat.match) begin
          cmd.adv_pair = 1'b1;
          state_next   = S_PS_ADDR;
        end else if (!stat.pend_valid || out_free) begin
          // push out the held pair, keep the new one until its last flag is known
          cmd.emit        = stat.pend_valid;
          cmd.emit_status = ST_OK;
          cmd.emit_hold   = 1'b1;
          cmd.cap_pair    = 1'b1;
          cmd.adv_pair    = 1'b1;
          state_next      = stat.pair_limit ? S_PS_END : S_PS_ADDR;
        end
      end
      S_PS_END: begin
        if (out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = stat.pend_valid ? ST_OK : ST_NOPAIR;
          cmd.emit_hold   = stat.pend_valid;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = r_status;
          cmd.emit_hold   = r_hold;
          cmd.emit_last   = 1'b1;
          cmd.cnt_op      = r_cnt;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `OLPSE_ASSERT_NOW(a_emit_when_free, cmd.emit, out_free)
  `OLPSE_ASSERT_NEXT(a_fire_to_decode, req_fire, state == S_DECODE)
  `OLPSE_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state))

endmodule

[rtl/core/olpse_dpath.sv]
// datapath of the ordered list engine: element store, pointers, pair adder
// depends on olpse_pkg and the assertion macro header
`include "ordered_list_pair_sum_engine_macros.svh"

module olpse_dpath import olpse_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ACTION_W-1:0]       in_action,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [POS_W-1:0]          in_pos,
  input  logic signed [VALUE_W-1:0] in_target,
  input  dp_cmd_t                   cmd,
  output dp_status_t                stat,
  output logic signed [VALUE_W-1:0] res_first,
  output logic signed [VALUE_W-1:0] res_second
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  action_t                   act;
  logic signed [VALUE_W-1:0] val;
  logic [POS_W-1:0]          pos;
  logic signed [VALUE_W-1:0] tgt;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          i;
  logic [CNT_W-1:0]          j;
  logic [PAIR_W-1:0]         pairs;
  logic                      pend_valid;
  logic signed [VALUE_W-1:0] hold_a;
  logic signed [VALUE_W-1:0] hold_b;
  logic signed [VALUE_W-1:0] rdata_a;
  logic signed [VALUE_W-1:0] rdata_b;

  logic                      is_del;
  logic                      is_ins;
  logic [CNT_W-1:0]          idx;
  logic [CMP_W-1:0]          pos_w;
  logic [CMP_W-1:0]          cnt_w;
  logic [CNT_W-1:0]          ra;
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic [VALUE_W:0]          pair_sum;

  assign is_del = (act == ACT_DEL_HEAD) || (act == ACT_DEL_TAIL) || (act == ACT_DEL_POS);
  assign is_ins = (act == ACT_INS_HEAD) || (act == ACT_INS_TAIL) || (act == ACT_INS_POS);
  assign pos_w  = CMP_W'(pos);
  assign cnt_w  = CMP_W'(count);

  // 0-based slot that the edit works on
  always_comb begin
    case (act) inside
      ACT_INS_HEAD, ACT_DEL_HEAD: idx = '0;
      ACT_INS_TAIL:               idx = count;
      ACT_DEL_TAIL:               idx = count - CNT_W'(1);
      default:                    idx = CNT_W'(pos_w - CMP_W'(1));
    endcase
  end

  // shifts read the neighbor toward the vacated side
  always_comb begin
    if (cmd.shift_rd) begin
      ra = is_del ? (i + CNT_W'(1)) : (i - CNT_W'(1));
    end else begin
      ra = i;
    end
  end

  assign we    = cmd.wr_new || cmd.wr_shift;
  assign waddr = cmd.wr_new ? idx[IDX_W-1:0] : i[IDX_W-1:0];
  assign wdata = cmd.wr_new ? val : rdata_a;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[ra[IDX_W-1:0]];
    rdata_b <= mem[j[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action_t'(in_action);
      val <= in_value;
      pos <= in_pos;
      tgt <= in_target;
    end
    if (cmd.cap_read) begin
      hold_a <= rdata_a;
      hold_b <= '0;
    end else if (cmd.cap_pair) begin
      hold_a <= rdata_a;
      hold_b <= rdata_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      i          <= '0;
      j          <= '0;
      pairs      <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: count <= count + CNT_W'(1);
        CNT_DEC: count <= count - CNT_W'(1);
        CNT_CLR: count <= '0;
        default: count <= count;
      endcase

      if (cmd.start) begin
        i <= is_del ? idx : (is_ins ? count : '0);
        j <= CNT_W'(1);
      end else if (cmd.wr_shift) begin
        i <= is_del ? (i + CNT_W'(1)) : (i - CNT_W'(1));
      end else if (cmd.inc_i) begin
        i <= i + CNT_W'(1);
      end else if (cmd.adv_pair) begin
        if ((j + CNT_W'(1)) < count) begin
          j <= j + CNT_W'(1);
        end else begin
          i <= i + CNT_W'(1);
          j <= i + CNT_W'(2);
        end
      end

      if (cmd.start) begin
        pairs      <= '0;
        pend_valid <= 1'b0;
      end else if (cmd.cap_pair) begin
        pairs      <= pairs + PAIR_W'(1);
        pend_valid <= 1'b1;
      end
    end
  end

  // exact sum, one bit wider than the operands
  assign pair_sum = {rdata_a[VALUE_W-1], rdata_a} + {rdata_b[VALUE_W-1], rdata_b};

  always_comb begin
    stat               = '0;
    stat.act           = act;
    stat.empty         = (count == '0);
    stat.full          = (count >= CNT_W'(DEPTH));
    stat.bad_ins_pos   = (pos == '0) || (pos_w > (cnt_w + CMP_W'(1)));
    stat.bad_del_pos   = (pos == '0) || (pos_w > cnt_w);
    stat.is_del        = is_del;
    stat.shift_more    = is_del ? ((i + CNT_W'(1)) < count) : (i > idx);
    stat.rd_last       = ((i + CNT_W'(1)) == count);
    stat.pair_in_range = (j < count);
    stat.match         = (pair_sum == {tgt[VALUE_W-1], tgt});
    stat.pair_limit    = ((pairs + PAIR_W'(1)) == PAIR_W'(MAX_OUT));
    stat.pend_valid    = pend_valid;
  end

  assign res_first  = cmd.emit_hold ? hold_a : '0;
  assign res_second = cmd.emit_hold ? hold_b : '0;

  `OLPSE_ASSERT_NOW(a_count_in_range, 1'b1, count <= CNT_W'(DEPTH))
  `OLPSE_ASSERT_NOW(a_shift_in_store, cmd.wr_shift, i < CNT_W'(DEPTH))
  `OLPSE_ASSERT_NOW(a_pairs_in_range, 1'b1, pairs <= PAIR_W'(MAX_OUT))

endmodule

[rtl/core/ordered_list_pair_sum_engine.sv]
// Ordered list of up to DEPTH signed 32-bit values with positional edits,
// read-out and a two-sum pair search. One request transaction (action,
// item_value, list_position, target_sum) comes in on req; one or more response
// transactions (status, first_value, second_value, last) go out on rsp, and
// the final one of a request carries last.
// Requests are taken one at a time: req.ready is high only while the
// controller is idle and out of reset. An action that needs no store access
// (an error, clear, or a read or search of an empty list) goes from decode
// straight to the reply state, which loads its response. Inserts and deletes
// shift entries one at a time through the one-write-port store: each moved
// entry is read, then written one slot over. Read-all emits one element per
// response; pair search walks the element pairs in order and ends with a tail
// state that sends the last held pair or a no-pair status.
// A response sits in an output register; a new request may be accepted while
// the last response of the previous one waits there. When rsp stalls, the
// controller holds its place until the register is free, nothing is dropped.
// Reset empties the list and clears the output register; store contents are
// left as they are, and no entry is read before it is written.
// depends on olpse_pkg, olpse_if, olpse_ctrl and olpse_dpath
module ordered_list_pair_sum_engine import olpse_pkg::*; (
  input logic         clk,
  input logic         rst,
  olpse_req_if.sink   req,
  olpse_rsp_if.source rsp
);

  dp_cmd_t                   cmd;
  dp_status_t                stat;
  logic                      idle;
  logic                      req_fire;
  logic                      out_free;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] res_first;
  logic signed [VALUE_W-1:0] res_second;

  assign req.ready = idle && !rst;
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  olpse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req_fire (req_fire),
    .out_free (out_free),
    .stat     (stat),
    .idle     (idle),
    .cmd      (cmd)
  );

  olpse_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_action  (req.action),
    .in_value   (req.item_value),
    .in_pos     (req.list_position),
    .in_target  (req.target_sum),
    .cmd        (cmd),
    .stat       (stat),
    .res_first  (res_first),
    .res_second (res_second)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.status       <= cmd.emit_status;
      rsp.first_value  <= res_first;
      rsp.second_value <= res_second;
      rsp.last         <= cmd.emit_last;
    end
  end

endmodule

[sim/tb.sv]
// self-checking bench for the ordered list pair-sum engine: directed and random
// requests with random idle bursts on both channels, predicted replies in order
// depends on olpse_pkg, olpse_if and the ordered_list_pair_sum_engine rtl
module tb import olpse_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 430;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int CALM_ITEMS   = 50;

  typedef struct {
    logic [ACTION_W-1:0]       action;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] target;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] first;
    logic signed [VALUE_W-1:0] second;
    logic                      last;
  } reply_t;

  logic clk;
  logic rst;

  olpse_req_if req_ch ();
  olpse_rsp_if rsp_ch ();

  ordered_list_pair_sum_engine u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  request_t cur_request;
  reply_t   want_reply;

  // shadow copy of the list
  logic signed [VALUE_W-1:0] shadow_list[DEPTH];
  int shadow_len;

  int err_count = 0;
  int send_gap_left;
  int send_quiet_left;
  int recv_stall_left;
  int recv_quiet_left;
  int idle_cycles;
  logic calm;
  logic timed_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_error(string msg);
    $display("error: %s", msg);
    err_count++;
  endtask

  task automatic push_reply(logic [STATUS_W-1:0] status, logic signed [VALUE_W-1:0] first,
                            logic signed [VALUE_W-1:0] second, logic last);
    reply_t r;
    r.status = status;
    r.first  = first;
    r.second = second;
    r.last   = last;
    expected_replies.push_back(r);
  endtask

  task automatic insert_entry(int idx, logic signed [VALUE_W-1:0] v);
    for (int i = shadow_len; i > idx; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[idx] = v;
    shadow_len++;
  endtask

  function automatic logic signed [VALUE_W-1:0] remove_entry(int idx);
    logic signed [VALUE_W-1:0] v;
    v = shadow_list[idx];
    for (int i = idx; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
    shadow_len--;
    return v;
  endfunction

  // applies one accepted request to the shadow list and queues its replies
  task automatic compute_replies(request_t rq);
    logic signed [VALUE_W-1:0] pa[MAX_OUT];
    logic signed [VALUE_W-1:0] pb[MAX_OUT];
    int k;
    int p;
    p = rq.pos;
    case (rq.action)
      ACT_INS_HEAD, ACT_INS_TAIL: begin
        if (shadow_len >= DEPTH) begin
          push_reply(ST_FULL, 0, 0, 1'b1);
        end else begin
          insert_entry((rq.action == ACT_INS_HEAD) ? 0 : shadow_len, rq.value);
          push_reply(ST_OK, 0, 0, 1'b1);
        end
      end
      ACT_INS_POS: begin
        if (p == 0 || p > shadow_len + 1) begin
          push_reply(ST_BADPOS, 0, 0, 1'b1);
        end else if (shadow_len >= DEPTH) begin
          push_reply(ST_FULL, 0, 0, 1'b1);
        end else begin
          insert_entry(p - 1, rq.value);
          push_reply(ST_OK, 0, 0, 1'b1);
        end
      end
      ACT_DEL_HEAD, ACT_DEL_TAIL: begin
        if (shadow_len == 0) begin
          push_reply(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          push_reply(ST_OK, remove_entry((rq.action == ACT_DEL_HEAD) ? 0 : shadow_len - 1),
                     0, 1'b1);
        end
      end
      ACT_DEL_POS: begin
        if (shadow_len == 0) begin
          push_reply(ST_EMPTY, 0, 0, 1'b1);
        end else if (p == 0 || p > shadow_len) begin
          push_reply(ST_BADPOS, 0, 0, 1'b1);
        end else begin
          push_reply(ST_OK, remove_entry(p - 1), 0, 1'b1);
        end
      end
      ACT_READ_ALL: begin
        if (shadow_len == 0) begin
          push_reply(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++)
            push_reply(ST_OK, shadow_list[i], 0, i == shadow_len - 1);
        end
      end
      ACT_PAIR: begin
        if (shadow_len == 0) begin
          push_reply(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          k = 0;
          for (int i = 0; i < shadow_len; i++) begin
            for (int j = i + 1; j < shadow_len; j++) begin
              // exact sum, no wrap
              if (k < MAX_OUT &&
                  longint'(shadow_list[i]) + longint'(shadow_list[j]) == longint'(rq.target)) begin
                pa[k] = shadow_list[i];
                pb[k] = shadow_list[j];
                k++;
              end
            end
          end
          if (k == 0) begin
            push_reply(ST_NOPAIR, 0, 0, 1'b1);
          end else begin
            for (int i = 0; i < k; i++) push_reply(ST_OK, pa[i], pb[i], i == k - 1);
          end
        end
      end
      ACT_CLEAR: begin
        shadow_len = 0;
        push_reply(ST_OK, 0, 0, 1'b1);
      end
      default: begin
        // unused codes are dropped silently
      end
    endcase
  endtask

  task automatic queue_request(logic [ACTION_W-1:0] action, logic signed [VALUE_W-1:0] value,
                               logic [POS_W-1:0] pos, logic signed [VALUE_W-1:0] target);
    request_t rq;
    rq.action = action;
    rq.value  = value;
    rq.pos    = pos;
    rq.target = target;
    pending_requests.push_back(rq);
  endtask

  // small values make pair matches common, extremes probe the 33-bit sum
  function automatic logic signed [VALUE_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0, 1, 2: return $urandom_range(0, 8) - 4;
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 2)
                                     : 32'h8000_0000 + $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      calm         <= 1'b0;
      send_gap_left   = 0;
      send_quiet_left = 0;
      shadow_len      = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        compute_replies(cur_request);
        if (!calm) begin
          if (send_quiet_left > 0) send_quiet_left--;
          else if ($urandom_range(0, 15) == 0) send_quiet_left = $urandom_range(10, 40);
          else if ($urandom_range(0, 3) == 0) send_gap_left = $urandom_range(1, 11);
        end
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap_left > 0 && !calm) begin
          send_gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cur_request = pending_requests.pop_front();
          req_ch.action        <= cur_request.action;
          req_ch.item_value    <= cur_request.value;
          req_ch.list_position <= cur_request.pos;
          req_ch.target_sum    <= cur_request.target;
          req_ch.valid         <= 1'b1;
          if (pending_requests.size() < CALM_ITEMS) calm <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and response-side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_stall_left = 0;
      recv_quiet_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_replies.size() == 0) begin
          report_error($sformatf("unexpected transaction status %0d first %0d second %0d",
                                 rsp_ch.status, rsp_ch.first_value, rsp_ch.second_value));
        end else begin
          want_reply = expected_replies.pop_front();
          if (rsp_ch.status !== want_reply.status)
            report_error($sformatf("status got %0d want %0d", rsp_ch.status,
                                   want_reply.status));
          if (rsp_ch.first_value !== want_reply.first)
            report_error($sformatf("first_value got %0d want %0d", rsp_ch.first_value,
                                   want_reply.first));
          if (rsp_ch.second_value !== want_reply.second)
            report_error($sformatf("second_value got %0d want %0d", rsp_ch.second_value,
                                   want_reply.second));
          if (rsp_ch.last !== want_reply.last)
            report_error($sformatf("last got %0b want %0b", rsp_ch.last, want_reply.last));
        end
      end
      if (calm) begin
        rsp_ch.ready <= 1'b1;
      end else if (recv_stall_left > 0) begin
        recv_stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (recv_quiet_left > 0) begin
        recv_quiet_left--;
        rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 39) == 0) begin
        recv_quiet_left = $urandom_range(20, 80);
        rsp_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        recv_stall_left = $urandom_range(1, 11) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
      timed_out   <= 1'b0;
    end else begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin
    int generated;
    int chunk_left;
    int fill_pct;
    int r;
    logic [ACTION_W-1:0] act;
    logic signed [VALUE_W-1:0] tgt;
    logic [POS_W-1:0] pos;

    rst = 1'b1;

    // directed: empty list cases
    queue_request(ACT_READ_ALL, 0, 0, 0);
    queue_request(ACT_PAIR, 0, 0, 0);
    queue_request(ACT_DEL_HEAD, 0, 0, 0);
    queue_request(ACT_INS_POS, 5, 0, 0);
    queue_request(ACT_INS_POS, 5, 2, 0);
    // extremes; max plus one must not match the wrapped target
    queue_request(ACT_INS_TAIL, 32'h7fff_ffff, 0, 0);
    queue_request(ACT_INS_HEAD, 1, 0, 0);
    queue_request(ACT_PAIR, 0, 0, 32'h8000_0000);
    queue_request(ACT_INS_POS, 32'h8000_0000, 3, 0);
    queue_request(ACT_INS_POS, -1, 1, 0);
    queue_request(ACT_PAIR, 0, 0, -1);
    queue_request(ACT_DEL_POS, 0, 0, 0);
    queue_request(ACT_DEL_POS, 0, 2, 0);
    queue_request(ACTION_W'(ACT_CLEAR + 7), 0, 4'hf, 0);
    queue_request(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < DEPTH; i++)
      queue_request((i % 3 == 0) ? ACT_INS_HEAD : (i % 3 == 1) ? ACT_INS_TAIL : ACT_INS_POS,
                    0, 1, 0);
    // full list: bad position wins over full
    queue_request(ACT_INS_POS, 7, 4'hf, 0);
    queue_request(ACT_INS_POS, 7, POS_W'(DEPTH + 1), 0);
    queue_request(ACT_PAIR, 0, 0, 0);
    queue_request(ACT_READ_ALL, 0, 0, 0);

    generated = 0;
    chunk_left = 0;
    fill_pct = 40;
    while (generated < RANDOM_ITEMS) begin
      if (chunk_left == 0) begin
        chunk_left = $urandom_range(20, 60);
        fill_pct = $urandom_range(0, 1) ? 65 : 40;
      end
      r = $urandom_range(0, 99);
      if (r < 3) act = ACTION_W'($urandom_range(ACT_CLEAR + 1, 15));
      else if (r < 3 + fill_pct) act = ACTION_W'($urandom_range(ACT_INS_HEAD, ACT_INS_POS));
      else if (r < 82) act = ACTION_W'($urandom_range(ACT_DEL_HEAD, ACT_DEL_POS));
      else if (r < 88) act = ACT_READ_ALL;
      else if (r < 98) act = ACT_PAIR;
      else act = ACT_CLEAR;
      pos = ($urandom_range(0, 3) == 0) ? POS_W'($urandom_range(0, 15))
                                        : POS_W'($urandom_range(1, DEPTH + 1));
      case ($urandom_range(0, 3))
        0, 1: tgt = rand_word() + rand_word();
        2: tgt = rand_word();
        default: tgt = -1;
      endcase
      queue_request(act, rand_word(), pos, tgt);
      if (act <= ACT_CLEAR) begin
        generated++;
        chunk_left--;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while ((pending_requests.size() > 0 || req_ch.valid) && !timed_out) @(posedge clk);
    while (expected_replies.size() > 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_replies.size() > 0)
      report_error($sformatf("%0d expected transactions never arrived",
                             expected_replies.size()));
    if (!timed_out && err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
